>>> rtl/sha512_pkg.sv
// Shared types and constants for the SHA-512 hash engine.
package sha512_pkg;

  typedef logic [63:0] word_t;
  typedef logic [7:0][63:0] chain_t;

  // Control from the sequencer to the round unit.
  typedef struct packed {
    logic       push;
    logic       load;
    logic       step;
    word_t      word;
    logic [6:0] round;
  } rnd_ctl_t;

  localparam int unsigned NUM_ROUNDS = 80;

  localparam chain_t INIT_HASH = '{
    0: 64'h6a09e667f3bcc908, 1: 64'hbb67ae8584caa73b,
    2: 64'h3c6ef372fe94f82b, 3: 64'ha54ff53a5f1d36f1,
    4: 64'h510e527fade682d1, 5: 64'h9b05688c2b3e6c1f,
    6: 64'h1f83d9abfb41bd6b, 7: 64'h5be0cd19137e2179
  };

  localparam word_t ROUND_K [0:NUM_ROUNDS-1] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f,
    64'he9b5dba58189dbbc, 64'h3956c25bf348b538, 64'h59f111f1b605d019,
    64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118, 64'hd807aa98a3030242,
    64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235,
    64'hc19bf174cf692694, 64'he49b69c19ef14ad2, 64'hefbe4786384f25e3,
    64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65, 64'h2de92c6f592b0275,
    64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f,
    64'hbf597fc7beef0ee4, 64'hc6e00bf33da88fc2, 64'hd5a79147930aa725,
    64'h06ca6351e003826f, 64'h142929670a0e6e70, 64'h27b70a8546d22ffc,
    64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6,
    64'h92722c851482353b, 64'ha2bfe8a14cf10364, 64'ha81a664bbc423001,
    64'hc24b8b70d0f89791, 64'hc76c51a30654be30, 64'hd192e819d6ef5218,
    64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99,
    64'h34b0bcb5e19b48a8, 64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb,
    64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3, 64'h748f82ee5defb2fc,
    64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915,
    64'hc67178f2e372532b, 64'hca273eceea26619c, 64'hd186b8c721c0c207,
    64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178, 64'h06f067aa72176fba,
    64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc,
    64'h431d67c49c100d4c, 64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a,
    64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

endpackage

>>> rtl/sha512_if.sv
// Valid/ready channel interfaces for message words and digest words.
interface sha512_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] message_word;
  logic [3:0]  valid_bytes;
  logic        final_word;

  modport source (output valid, message_word, valid_bytes, final_word, input ready);
  modport sink (input valid, message_word, valid_bytes, final_word, output ready);
endinterface

interface sha512_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic [2:0]  digest_index;
  logic        digest_last;

  modport source (output valid, digest_word, digest_index, digest_last, input ready);
  modport sink (input valid, digest_word, digest_index, digest_last, output ready);
endinterface

>>> rtl/sha512_hash_engine.sv
// SHA-512 hash engine top level: block sequencer, padding, length and digest output.
//
// Usage: message words enter on in_chan (valid/ready), big-endian, one transaction
// per 64-bit word; final_word marks the last word, whose valid_bytes gives its
// leading valid bytes (values above 8 count as 8). Digest words leave on
// out_chan, eight transactions with digest_index 0..7, digest_last on the eighth.
// Timing: a word that does not complete a 128-byte block is pushed into the round
// unit's message window. A word that completes a block is followed by a busy
// stretch (80 rounds through the shared round unit, then the S_ADD state folds the
// result into the chaining value). The final word starts padding: one padding word
// per cycle pushed up to the block end, then each padded block is compressed in the
// same way (two blocks when the pad byte lands at byte 112 or later), then the
// eight digest words, one per cycle when out_chan.ready is high.
// in_chan.ready is high only while the engine waits for a word; a stalled
// receiver simply holds the engine in the output phase with the word stable.
// Reset (rst_n low, synchronous) loads the initial hash values and clears the
// fill position, bit length and all control state.
module sha512_hash_engine (
  input  logic                clk,
  input  logic                rst_n,
  sha512_in_if.sink           in_chan,
  sha512_out_if.source        out_chan
);
  import sha512_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_COMP,
    S_ADD,
    S_OUT
  } state_t;

  localparam logic [3:0]  LAST_SLOT  = 4'd15;
  localparam logic [3:0]  LEN_SLOT   = 4'd14;
  localparam logic [3:0]  FULL_BYTES = 4'd8;
  localparam logic [6:0]  LAST_ROUND = 7'(NUM_ROUNDS - 1);
  localparam logic [2:0]  LAST_INDEX = 3'd7;
  localparam word_t       WORD_BITS  = 64'd64;
  localparam word_t       PAD_LEAD   = 64'h8000000000000000;

  state_t     state_r, state_nxt;
  logic [3:0] fill_r, fill_nxt;
  word_t      len_r, len_nxt;
  chain_t     chain_r, chain_nxt;
  logic [6:0] rnd_r, rnd_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       pend_r, pend_nxt;    // 0x80 word still owed after a full final word
  logic       extra_r, extra_nxt;  // length does not fit: one more zero block
  logic       fin_r, fin_nxt;      // final word seen, padding in progress
  logic       done_r, done_nxt;    // length word pushed, digest after this block

  rnd_ctl_t   ctl;
  chain_t     work;
  logic       in_acc;
  logic       out_acc;
  logic [3:0] nb_sat;
  logic       nb_full;

  // Keep leading bytes, put the 0x80 marker after them, zero the rest.
  function automatic word_t pad_word(input word_t w, input logic [2:0] n);
    word_t r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (3'(i) < n) r[63-8*i -: 8] = w[63-8*i -: 8];
      else if (3'(i) == n) r[63-8*i -: 8] = 8'h80;
    end
    return r;
  endfunction

  sha512_round u_round (
    .clk   (clk),
    .ctl   (ctl),
    .chain (chain_r),
    .work  (work)
  );

  assign in_chan.ready         = (state_r == S_IDLE);
  assign in_acc                = in_chan.valid && in_chan.ready;
  assign out_chan.valid        = (state_r == S_OUT);
  assign out_chan.digest_word  = chain_r[idx_r];
  assign out_chan.digest_index = idx_r;
  assign out_chan.digest_last  = (idx_r == LAST_INDEX);
  assign out_acc               = out_chan.valid && out_chan.ready;

  assign nb_full = in_chan.valid_bytes[3];
  assign nb_sat  = nb_full ? FULL_BYTES : in_chan.valid_bytes;

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    len_nxt   = len_r;
    chain_nxt = chain_r;
    rnd_nxt   = rnd_r;
    idx_nxt   = idx_r;
    pend_nxt  = pend_r;
    extra_nxt = extra_r;
    fin_nxt   = fin_r;
    done_nxt  = done_r;
    ctl       = '0;
    ctl.round = rnd_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          ctl.push = 1'b1;
          fill_nxt = fill_r + 4'd1;
          if (!in_chan.final_word || nb_full) begin
            ctl.word = in_chan.message_word;
            len_nxt  = len_r + WORD_BITS;
          end else begin
            ctl.word  = pad_word(in_chan.message_word, nb_sat[2:0]);
            len_nxt   = len_r + {57'd0, nb_sat, 3'd0};
            extra_nxt = (fill_r == LEN_SLOT);
          end
          if (in_chan.final_word) begin
            fin_nxt  = 1'b1;
            pend_nxt = nb_full;
          end
          if (fill_r == LAST_SLOT) begin
            ctl.load  = 1'b1;
            rnd_nxt   = '0;
            state_nxt = S_COMP;
          end else if (in_chan.final_word) begin
            state_nxt = S_PAD;
          end
        end
      end

      S_PAD: begin
        ctl.push = 1'b1;
        fill_nxt = fill_r + 4'd1;
        if (pend_r) begin
          ctl.word  = PAD_LEAD;
          pend_nxt  = 1'b0;
          extra_nxt = (fill_r == LEN_SLOT);
        end else if (fill_r == LAST_SLOT && extra_r) begin
          ctl.word  = '0;
          extra_nxt = 1'b0;
        end else if (fill_r == LAST_SLOT) begin
          ctl.word = len_r;
          done_nxt = 1'b1;
        end else begin
          ctl.word = '0;
        end
        if (fill_r == LAST_SLOT) begin
          ctl.load  = 1'b1;
          rnd_nxt   = '0;
          state_nxt = S_COMP;
        end
      end

      S_COMP: begin
        ctl.step = 1'b1;
        rnd_nxt  = rnd_r + 7'd1;
        if (rnd_r == LAST_ROUND) state_nxt = S_ADD;
      end

      S_ADD: begin
        for (int i = 0; i < 8; i++) chain_nxt[i] = chain_r[i] + work[i];
        if (done_r) begin
          idx_nxt   = '0;
          state_nxt = S_OUT;
        end else if (fin_r) begin
          state_nxt = S_PAD;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_OUT: begin
        if (out_acc) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == LAST_INDEX) begin
            // Drop back to the initial values for the next message.
            chain_nxt = INIT_HASH;
            len_nxt   = '0;
            fin_nxt   = 1'b0;
            done_nxt  = 1'b0;
            extra_nxt = 1'b0;
            pend_nxt  = 1'b0;
            state_nxt = S_IDLE;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      len_r   <= '0;
      chain_r <= INIT_HASH;
      rnd_r   <= '0;
      idx_r   <= '0;
      pend_r  <= 1'b0;
      extra_r <= 1'b0;
      fin_r   <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      len_r   <= len_nxt;
      chain_r <= chain_nxt;
      rnd_r   <= rnd_nxt;
      idx_r   <= idx_nxt;
      pend_r  <= pend_nxt;
      extra_r <= extra_nxt;
      fin_r   <= fin_nxt;
      done_r  <= done_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // Digest output only ever starts from an empty block buffer.
  a_out_fill_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (fill_r == '0))
    else $error("digest output with words left in the block buffer");

  // Message intake and digest output never overlap.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_chan.ready && out_chan.valid))
    else $error("input ready while digest output is pending");

  // After the last digest word, the engine is back at its initial values.
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_chan.digest_last) |=> (chain_r == INIT_HASH) && (len_r == '0))
    else $error("chaining value or length not reinitialized after digest");

  // A block push at the last slot always starts a compression.
  a_full_compress: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.push && fill_r == LAST_SLOT) |=> (state_r == S_COMP) && (rnd_r == '0))
    else $error("full block not compressed");

  // The round counter stays inside the round table while compressing.
  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMP) |-> (rnd_r <= LAST_ROUND))
    else $error("round counter out of range");
`endif

endmodule

>>> rtl/sha512_round.sv
// SHA-512 round unit: message schedule window and working variables, one round per cycle.
module sha512_round (
  input  logic                 clk,
  input  sha512_pkg::rnd_ctl_t ctl,
  input  sha512_pkg::chain_t   chain,
  output sha512_pkg::chain_t   work
);
  import sha512_pkg::*;

  word_t  win_r [0:15];
  chain_t s_r;

  word_t sched_new;
  word_t t1;
  word_t t2;

  function automatic word_t rotr(input word_t v, input int unsigned r);
    rotr = (v >> r) | (v << (64 - r));
  endfunction

  always_comb begin
    sched_new = win_r[0]
              + (rotr(win_r[1], 1) ^ rotr(win_r[1], 8) ^ (win_r[1] >> 7))
              + win_r[9]
              + (rotr(win_r[14], 19) ^ rotr(win_r[14], 61) ^ (win_r[14] >> 6));
    t1 = s_r[7]
       + (rotr(s_r[4], 14) ^ rotr(s_r[4], 18) ^ rotr(s_r[4], 41))
       + ((s_r[4] & s_r[5]) ^ (~s_r[4] & s_r[6]))
       + ROUND_K[ctl.round]
       + win_r[0];
    t2 = (rotr(s_r[0], 28) ^ rotr(s_r[0], 34) ^ rotr(s_r[0], 39))
       + ((s_r[0] & s_r[1]) ^ (s_r[0] & s_r[2]) ^ (s_r[1] & s_r[2]));
  end

  // Window slides toward index 0; new words enter at index 15.
  always_ff @(posedge clk) begin
    if (ctl.step) begin
      for (int i = 0; i < 15; i++) win_r[i] <= win_r[i+1];
      win_r[15] <= sched_new;
      s_r[7] <= s_r[6];
      s_r[6] <= s_r[5];
      s_r[5] <= s_r[4];
      s_r[4] <= s_r[3] + t1;
      s_r[3] <= s_r[2];
      s_r[2] <= s_r[1];
      s_r[1] <= s_r[0];
      s_r[0] <= t1 + t2;
    end else begin
      if (ctl.push) begin
        for (int i = 0; i < 15; i++) win_r[i] <= win_r[i+1];
        win_r[15] <= ctl.word;
      end
      if (ctl.load) begin
        s_r <= chain;
      end
    end
  end

  assign work = s_r;

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the SHA-512 hash engine: word stream in, digest words out.
module testbench;
  import sha512_pkg::*;

  // One message word as offered on the input channel. hold_for_drain makes
  // the driver wait until every outstanding digest word has come back.
  typedef struct {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        fin;
    bit          hold_for_drain;
  } msg_beat_t;

  // One digest word as it must appear on the output channel.
  typedef struct {
    logic [63:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_beat_t;

  // Word patterns for message content.
  typedef enum int {PAT_MIXED, PAT_ONES, PAT_ZEROS} word_pat_t;

  localparam int IDLE_PCT       = 12;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int DRAIN_CYCLES   = 200;
  localparam int TARGET_BEATS   = 210;

  // Round constants and initial hash values of the standard, kept here so
  // that the expected digests do not lean on the tables inside the block.
  localparam logic [63:0] SHA_K [0:79] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f,
    64'he9b5dba58189dbbc, 64'h3956c25bf348b538, 64'h59f111f1b605d019,
    64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118, 64'hd807aa98a3030242,
    64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235,
    64'hc19bf174cf692694, 64'he49b69c19ef14ad2, 64'hefbe4786384f25e3,
    64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65, 64'h2de92c6f592b0275,
    64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f,
    64'hbf597fc7beef0ee4, 64'hc6e00bf33da88fc2, 64'hd5a79147930aa725,
    64'h06ca6351e003826f, 64'h142929670a0e6e70, 64'h27b70a8546d22ffc,
    64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6,
    64'h92722c851482353b, 64'ha2bfe8a14cf10364, 64'ha81a664bbc423001,
    64'hc24b8b70d0f89791, 64'hc76c51a30654be30, 64'hd192e819d6ef5218,
    64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99,
    64'h34b0bcb5e19b48a8, 64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb,
    64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3, 64'h748f82ee5defb2fc,
    64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915,
    64'hc67178f2e372532b, 64'hca273eceea26619c, 64'hd186b8c721c0c207,
    64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178, 64'h06f067aa72176fba,
    64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc,
    64'h431d67c49c100d4c, 64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a,
    64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  localparam logic [63:0] SHA_IV [0:7] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
    64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  logic clk;
  logic rst_n;

  sha512_in_if  in_chan ();
  sha512_out_if out_chan ();

  sha512_hash_engine dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Pending message words and the digest words still owed by the block.
  msg_beat_t    beat_q[$];
  digest_beat_t digest_q[$];
  msg_beat_t    beat_on_bus;

  // Running hash context of the predictor.
  logic [63:0] hash_state [0:7];
  logic [63:0] block_words [0:15];
  int unsigned block_fill;
  logic [63:0] msg_bits;

  int error_count      = 0;
  int beats_accepted   = 0;
  int messages_hashed  = 0;
  int extra_pad_blocks = 0;
  int saturated_finals = 0;
  int digests_checked  = 0;
  int stall_left       = 0;
  bit holdoff_done     = 1'b0;

  // Clock: period of 10.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor: a straight SHA-512 over the accepted words.
  // ---------------------------------------------------------------------
  function automatic logic [63:0] rotr64(input logic [63:0] v, input int r);
    return (v >> r) | (v << (64 - r));
  endfunction

  function automatic void compress_block();
    logic [63:0] sched [0:79];
    logic [63:0] s [0:7];
    logic [63:0] t1;
    logic [63:0] t2;
    for (int t = 0; t < 16; t++)
      sched[t] = block_words[t];
    for (int t = 16; t < 80; t++) begin
      sched[t] = sched[t-16] + sched[t-7]
               + (rotr64(sched[t-15], 1) ^ rotr64(sched[t-15], 8) ^ (sched[t-15] >> 7))
               + (rotr64(sched[t-2], 19) ^ rotr64(sched[t-2], 61) ^ (sched[t-2] >> 6));
    end
    for (int i = 0; i < 8; i++)
      s[i] = hash_state[i];
    for (int t = 0; t < 80; t++) begin
      t1 = s[7] + (rotr64(s[4], 14) ^ rotr64(s[4], 18) ^ rotr64(s[4], 41))
         + ((s[4] & s[5]) ^ (~s[4] & s[6])) + SHA_K[t] + sched[t];
      t2 = (rotr64(s[0], 28) ^ rotr64(s[0], 34) ^ rotr64(s[0], 39))
         + ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
      s[7] = s[6];
      s[6] = s[5];
      s[5] = s[4];
      s[4] = s[3] + t1;
      s[3] = s[2];
      s[2] = s[1];
      s[1] = s[0];
      s[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++)
      hash_state[i] += s[i];
  endfunction

  function automatic void restart_hash();
    for (int i = 0; i < 8; i++)
      hash_state[i] = SHA_IV[i];
    block_fill = 0;
    msg_bits   = '0;
  endfunction

  // Buffer one word; a full block is compressed at once.
  function automatic void push_block_word(input logic [63:0] w);
    block_words[block_fill] = w;
    block_fill++;
    if (block_fill == 16) begin
      compress_block();
      block_fill = 0;
    end
  endfunction

  // Fold one accepted message word into the context; a final word pads,
  // finishes the digest and queues its eight words.
  function automatic void absorb_word(input msg_beat_t b);
    int unsigned nb;
    logic [63:0] keep;
    if (!b.fin) begin
      push_block_word(b.word);
      msg_bits += 64;
      return;
    end
    nb = (b.nbytes > 4'd8) ? 8 : b.nbytes;
    if (b.nbytes > 4'd8)
      saturated_finals++;
    if (nb == 8) begin
      // whole word is message; the pad byte opens the next word
      push_block_word(b.word);
      msg_bits += 64;
      push_block_word(64'h8000_0000_0000_0000);
    end else begin
      keep = (nb == 0) ? 64'd0 : (~64'd0 << (64 - 8 * nb));
      push_block_word((b.word & keep) | (64'h80 << (56 - 8 * nb)));
      msg_bits += 8 * nb;
    end
    // no room left for the length: zero out this block and open another
    if (block_fill > 14) begin
      extra_pad_blocks++;
      while (block_fill != 0)
        push_block_word(64'd0);
    end
    while (block_fill < 14) begin
      block_words[block_fill] = 64'd0;
      block_fill++;
    end
    block_words[14] = 64'd0;
    block_words[15] = msg_bits;
    compress_block();
    for (int k = 0; k < 8; k++)
      digest_q.push_back('{hash_state[k], 3'(k), (k == 7)});
    messages_hashed++;
    restart_hash();
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic logic [63:0] pick_word(input word_pat_t pat);
    int unsigned r;
    case (pat)
      PAT_ONES:  return ~64'd0;
      PAT_ZEROS: return 64'd0;
      default: begin
        r = $urandom_range(0, 9);
        if (r == 0)
          return 64'd0;
        if (r == 1)
          return ~64'd0;
        return {$urandom, $urandom};
      end
    endcase
  endfunction

  // Queue a message of body_len full words plus one final word. Non-final
  // words carry a random byte count, which the block must ignore.
  task automatic add_message(input int body_len, input logic [3:0] last_bytes,
                             input word_pat_t pat, input bit hold);
    msg_beat_t b;
    for (int i = 0; i <= body_len; i++) begin
      b.word           = pick_word(pat);
      b.fin            = (i == body_len);
      b.nbytes         = b.fin ? last_bytes : 4'($urandom_range(0, 15));
      b.hold_for_drain = hold && (i == 0);
      beat_q.push_back(b);
    end
  endtask

  // ---------------------------------------------------------------------
  // Driver: offer queued words, hold each until accepted, idle at random
  // except across a quiet stretch in the middle of the run.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : drive_words
    bit sender_quiet;
    bit may_offer;
    if (!rst_n) begin
      in_chan.valid        <= 1'b0;
      in_chan.message_word <= '0;
      in_chan.valid_bytes  <= '0;
      in_chan.final_word   <= 1'b0;
      restart_hash();
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        absorb_word(beat_on_bus);
        beats_accepted++;
      end
      if (!in_chan.valid || in_chan.ready) begin
        sender_quiet = (beats_accepted >= 80) && (beats_accepted < 140);
        may_offer = (beat_q.size() != 0)
                 && !(beat_q[0].hold_for_drain && digest_q.size() != 0)
                 && (sender_quiet || $urandom_range(0, 99) >= IDLE_PCT);
        if (may_offer) begin
          beat_on_bus = beat_q.pop_front();
          in_chan.valid        <= 1'b1;
          in_chan.message_word <= beat_on_bus.word;
          in_chan.valid_bytes  <= beat_on_bus.nbytes;
          in_chan.final_word   <= beat_on_bus.fin;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: check each digest transaction against the oldest expected
  // word, and drive ready with random stalls plus one long hold-off that
  // backs the engine up into its input.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : check_digests
    digest_beat_t want;
    bit receiver_quiet;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (digest_q.size() == 0) begin
          error_count++;
          $display("%0t: unexpected digest word: expected none, actual %h index %0d last %0b",
                   $time, out_chan.digest_word, out_chan.digest_index, out_chan.digest_last);
        end else begin
          want = digest_q.pop_front();
          if (out_chan.digest_word !== want.word) begin
            error_count++;
            $display("%0t: digest_word mismatch: expected %h, actual %h",
                     $time, want.word, out_chan.digest_word);
          end
          if (out_chan.digest_index !== want.index) begin
            error_count++;
            $display("%0t: digest_index mismatch: expected %0d, actual %0d",
                     $time, want.index, out_chan.digest_index);
          end
          if (out_chan.digest_last !== want.last) begin
            error_count++;
            $display("%0t: digest_last mismatch: expected %0b, actual %0b",
                     $time, want.last, out_chan.digest_last);
          end
        end
        digests_checked++;
      end
      receiver_quiet = (digests_checked >= 56) && (digests_checked < 96);
      if (stall_left > 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else if (!holdoff_done && out_chan.valid && digests_checked >= 40) begin
        // hold off for a long stretch while the sender keeps offering
        holdoff_done = 1'b1;
        stall_left   = HOLDOFF_CYCLES;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= receiver_quiet || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------
  initial begin : run_messages
    int unsigned boundary_len [0:6];
    int planned;
    int msg_count;
    int unsigned r;
    int body;
    logic [3:0] last_bytes;

    boundary_len = '{13, 14, 15, 16, 29, 30, 31};
    clk   = 1'b0;
    rst_n = 1'b0;

    // Directed: empty message, full final word of ones, an over-range byte
    // count, a single valid byte with stray ones behind it, an odd count,
    // and a final word landing at byte 112 so a second pad block is needed.
    add_message(0, 4'd0, PAT_MIXED, 1'b0);
    add_message(0, 4'd8, PAT_ONES, 1'b0);
    add_message(0, 4'd15, PAT_MIXED, 1'b0);
    add_message(1, 4'd1, PAT_ONES, 1'b0);
    add_message(1, 4'd7, PAT_ZEROS, 1'b0);
    add_message(14, 4'd5, PAT_MIXED, 1'b0);

    // Random messages: mostly short, many sized around block boundaries,
    // some long. One of them waits for all digests to drain first.
    planned   = beat_q.size();
    msg_count = 0;
    while (planned < TARGET_BEATS) begin
      r = $urandom_range(0, 9);
      if (r < 4)
        body = $urandom_range(0, 6);
      else if (r < 7)
        body = boundary_len[$urandom_range(0, 6)];
      else
        body = $urandom_range(0, 40);
      r = $urandom_range(0, 9);
      if (r < 2)
        last_bytes = 4'd8;
      else if (r < 8)
        last_bytes = 4'($urandom_range(0, 8));
      else
        last_bytes = 4'($urandom_range(9, 15));
      add_message(body, last_bytes, PAT_MIXED, msg_count == 8);
      planned += body + 1;
      msg_count++;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until every word is taken, then until every digest is back.
    while (beat_q.size() != 0 || in_chan.valid)
      @(posedge clk);
    while (digest_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Hashed %0d messages from %0d words, %0d needing a second pad block,",
             messages_hashed, beats_accepted, extra_pad_blocks);
    $display("%0d with an over-range byte count; %0d digest words checked",
             saturated_finals, digests_checked);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Hard limit on the run.
  initial begin : watchdog
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

>>> sim.f
rtl/sha512_pkg.sv
rtl/sha512_if.sv
rtl/sha512_round.sv
rtl/sha512_hash_engine.sv
tb/sv/testbench.sv
